FILE: design/ba_pkg.sv
// ----------------------------------------------------------------------------
// ba_pkg
// shared types and constants of the buddy allocator
// ----------------------------------------------------------------------------
package ba_pkg;

    localparam int POOL_SIZE_LOG2 = 15;
    localparam int MIN_BLOCK_LOG2 = 5;
    localparam int LEVELS = POOL_SIZE_LOG2 - MIN_BLOCK_LOG2 + 1;
    localparam int NODES = (1 << LEVELS) - 1;
    localparam int NW = LEVELS + 1;
    localparam int LW = $clog2(LEVELS + 1);
    localparam int AW = LEVELS + 1;
    localparam int MDEPTH = 2 * (1 << LEVELS);

    localparam logic [NW-1:0] NIL = '1;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NULL = 3'd1;
    localparam logic [2:0] ST_NOMEM = 3'd2;
    localparam logic [2:0] ST_BADPOOL = 3'd3;
    localparam logic [2:0] ST_BADADDR = 3'd4;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE = 1'b1;

    localparam logic [0:0] REG_POOL0 = 1'd0;
    localparam logic [0:0] REG_POOL1 = 1'd1;

    typedef struct packed {
        logic        op;
        logic [1:0]  pool;
        logic [15:0] req_size;
        logic [31:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [31:0] addr_out;
        logic [2:0]  status;
    } rsp_t;

    // datapath memory operations
    localparam logic [3:0] DO_NONE = 4'd0;
    localparam logic [3:0] DO_RD_MARK = 4'd1;
    localparam logic [3:0] DO_WR_MARK = 4'd2;
    localparam logic [3:0] DO_RD_NEXT = 4'd3;
    localparam logic [3:0] DO_RD_PREV = 4'd4;
    localparam logic [3:0] DO_WR_NEXT = 4'd5;
    localparam logic [3:0] DO_WR_PREV = 4'd6;
    localparam logic [3:0] DO_RD_HEAD = 4'd7;
    localparam logic [3:0] DO_WR_HEAD = 4'd8;

    typedef struct packed {
        logic [3:0]    op;
        logic          pool;
        logic [NW-1:0] node;
        logic [LW-1:0] lvl;
        logic [NW-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [NW-1:0] rdata;
        logic          clear_done;
    } sts_t;

endpackage

FILE: design/ba_ram.sv
// ----------------------------------------------------------------------------
// ba_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module ba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: design/ba_datapath.sv
// ----------------------------------------------------------------------------
// ba_datapath
// mark, link and head storage for both pools; marks and links are cleared by a sweep after reset
// ----------------------------------------------------------------------------
module ba_datapath (
    input  logic         clk,
    input  logic         rst_n,
    input  ba_pkg::cmd_t cmd,
    output ba_pkg::sts_t sts
);

    localparam int MAW = $clog2(ba_pkg::MDEPTH);

    logic [MAW-1:0] clr_reg, clr_next;
    logic           clr_done_reg, clr_done_next;
    logic [1:0]     sel_reg, sel_next;

    logic [ba_pkg::NW-1:0] head_reg [2][ba_pkg::LEVELS];

    logic           m_we, n_we, p_we;
    logic [MAW-1:0] addr;
    logic [0:0]     m_wd, m_rd;
    logic [ba_pkg::NW-1:0] n_wd, p_wd, n_rd, p_rd, head_q_reg;

    always_comb
    begin
        clr_next = clr_reg;
        clr_done_next = clr_done_reg;
        m_we = 1'b0;
        n_we = 1'b0;
        p_we = 1'b0;
        m_wd = cmd.data[0:0];
        n_wd = cmd.data;
        p_wd = cmd.data;
        addr = {cmd.pool, cmd.node[ba_pkg::NW-2:0]};
        if (!clr_done_reg)
        begin
            addr = clr_reg;
            m_we = 1'b1;
            n_we = 1'b1;
            p_we = 1'b1;
            m_wd = 1'b0;
            n_wd = ba_pkg::NIL;
            p_wd = ba_pkg::NIL;
            clr_next = clr_reg + 1'b1;
            if (clr_reg == MAW'(ba_pkg::MDEPTH - 1))
            begin
                clr_done_next = 1'b1;
            end
        end
        else
        begin
            case (cmd.op)
                ba_pkg::DO_WR_MARK: m_we = 1'b1;
                ba_pkg::DO_WR_NEXT: n_we = 1'b1;
                ba_pkg::DO_WR_PREV: p_we = 1'b1;
                default: ;
            endcase
        end
        case (cmd.op)
            ba_pkg::DO_RD_MARK: sel_next = 2'd0;
            ba_pkg::DO_RD_NEXT: sel_next = 2'd1;
            ba_pkg::DO_RD_PREV: sel_next = 2'd2;
            default: sel_next = 2'd3;
        endcase
    end

    ba_ram #(.WIDTH(1), .DEPTH(ba_pkg::MDEPTH)) u_mark (
        .clk(clk), .we(m_we), .addr(addr), .wdata(m_wd), .rdata(m_rd));
    ba_ram #(.WIDTH(ba_pkg::NW), .DEPTH(ba_pkg::MDEPTH)) u_next (
        .clk(clk), .we(n_we), .addr(addr), .wdata(n_wd), .rdata(n_rd));
    ba_ram #(.WIDTH(ba_pkg::NW), .DEPTH(ba_pkg::MDEPTH)) u_prev (
        .clk(clk), .we(p_we), .addr(addr), .wdata(p_wd), .rdata(p_rd));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
            clr_done_reg <= 1'b0;
            sel_reg <= 2'd3;
            for (int p = 0; p < 2; p++)
            begin
                for (int l = 0; l < ba_pkg::LEVELS; l++)
                begin
                    head_reg[p][l] <= (l == 0) ? '0 : ba_pkg::NIL;
                end
            end
        end
        else
        begin
            clr_reg <= clr_next;
            clr_done_reg <= clr_done_next;
            sel_reg <= sel_next;
            if (cmd.op == ba_pkg::DO_WR_HEAD)
            begin
                head_reg[cmd.pool][cmd.lvl] <= cmd.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        head_q_reg <= head_reg[cmd.pool][cmd.lvl];
    end

    always_comb
    begin
        case (sel_reg)
            2'd0: sts.rdata = {{(ba_pkg::NW-1){1'b0}}, m_rd};
            2'd1: sts.rdata = n_rd;
            2'd2: sts.rdata = p_rd;
            default: sts.rdata = head_q_reg;
        endcase
        sts.clear_done = clr_done_reg;
    end

endmodule

FILE: design/ba_ctrl.sv
// ----------------------------------------------------------------------------
// ba_ctrl
// request sequencer: checks, list search, split, climb and merge
// ----------------------------------------------------------------------------
module ba_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  ba_pkg::req_t in_data,
    output logic         out_valid,
    input  logic         out_stall,
    output ba_pkg::rsp_t out_data,
    input  logic [31:0]  base0,
    input  logic [31:0]  base1,
    output ba_pkg::cmd_t cmd,
    input  ba_pkg::sts_t sts
);

    localparam int NW = ba_pkg::NW;
    localparam int LW = ba_pkg::LW;
    localparam int LV = ba_pkg::LEVELS;
    localparam int SW = 5;

    localparam logic [SW-1:0] S_IDLE = 5'd0;
    localparam logic [SW-1:0] S_SCAN = 5'd1;
    localparam logic [SW-1:0] S_SCAN_W = 5'd2;
    localparam logic [SW-1:0] S_UNL_N = 5'd3;
    localparam logic [SW-1:0] S_UNL_P = 5'd4;
    localparam logic [SW-1:0] S_UNL_A = 5'd5;
    localparam logic [SW-1:0] S_UNL_B = 5'd6;
    localparam logic [SW-1:0] S_UNL_C = 5'd7;
    localparam logic [SW-1:0] S_UNL_D = 5'd8;
    localparam logic [SW-1:0] S_POST = 5'd9;
    localparam logic [SW-1:0] S_PUSH_H = 5'd10;
    localparam logic [SW-1:0] S_PUSH_A = 5'd11;
    localparam logic [SW-1:0] S_PUSH_B = 5'd12;
    localparam logic [SW-1:0] S_PUSH_C = 5'd13;
    localparam logic [SW-1:0] S_SPLIT = 5'd14;
    localparam logic [SW-1:0] S_CLIMB = 5'd15;
    localparam logic [SW-1:0] S_CLIMB_W = 5'd16;
    localparam logic [SW-1:0] S_CH1 = 5'd17;
    localparam logic [SW-1:0] S_CH2 = 5'd18;
    localparam logic [SW-1:0] S_CH_W = 5'd19;
    localparam logic [SW-1:0] S_MERGE = 5'd20;
    localparam logic [SW-1:0] S_BUD = 5'd21;
    localparam logic [SW-1:0] S_BUD_W = 5'd22;
    localparam logic [SW-1:0] S_DONE = 5'd23;
    localparam logic [SW-1:0] S_OUT = 5'd24;
    localparam logic [SW-1:0] S_CH_W2 = 5'd25;

    // after-unlink and after-push continuations
    localparam logic [1:0] K_ALLOC = 2'd0;
    localparam logic [1:0] K_MERGE = 2'd1;
    localparam logic [1:0] K_SPLIT = 2'd2;
    localparam logic [1:0] K_END = 2'd3;

    logic [SW-1:0] state_reg, state_next;
    logic          op_reg, op_next, pool_reg, pool_next;
    logic [LW-1:0] lvl_reg, lvl_next, j_reg, j_next;
    logic [NW-1:0] t_reg, t_next, un_reg, un_next, pv_reg, pv_next, nx_reg, nx_next;
    logic [NW-1:0] hd_reg, hd_next;
    logic [1:0]    k_reg, k_next;
    logic [LV-2:0] x_reg, x_next;
    logic [31:0]   base_reg, base_next;
    logic [31:0]   addr_reg, addr_next;
    logic [2:0]    st_reg, st_next;
    logic          ch_reg, ch_next;
    logic          obuf_valid_reg, obuf_valid_next;
    ba_pkg::rsp_t  obuf_reg, obuf_next;

    logic [31:0]   off;
    logic [16:0]   need;
    logic [LW-1:0] pwr;
    logic [LW-1:0] alvl;
    logic [NW-1:0] leaf_t;
    logic [NW-1:0] lvl_first;
    logic [31:0]   boff;

    always_comb
    begin
        need = (in_data.req_size < 16'(1 << ba_pkg::MIN_BLOCK_LOG2))
            ? 17'(1 << ba_pkg::MIN_BLOCK_LOG2) : {1'b0, in_data.req_size};
        pwr = LW'(ba_pkg::POOL_SIZE_LOG2);
        for (int i = ba_pkg::POOL_SIZE_LOG2; i >= 0; i--)
        begin
            if ((17'd1 << i) >= need)
            begin
                pwr = LW'(i);
            end
        end
        alvl = LW'(ba_pkg::POOL_SIZE_LOG2) - pwr;
        if (alvl > LW'(LV - 1))
        begin
            alvl = LW'(LV - 1);
        end
        off = in_data.block_addr - (in_data.pool[0] ? base1 : base0);
        x_next = (state_reg == S_IDLE)
            ? off[ba_pkg::POOL_SIZE_LOG2-1:ba_pkg::MIN_BLOCK_LOG2] : x_reg;
        leaf_t = {2'b00, x_reg} + NW'((1 << (LV - 1)) - 1);
        lvl_first = (NW'(1) << j_reg) - NW'(1);
        boff = 32'(t_reg - lvl_first) << (LW'(ba_pkg::POOL_SIZE_LOG2) - j_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        pool_next = pool_reg;
        lvl_next = lvl_reg;
        j_next = j_reg;
        t_next = t_reg;
        un_next = un_reg;
        pv_next = pv_reg;
        nx_next = nx_reg;
        hd_next = hd_reg;
        k_next = k_reg;
        base_next = base_reg;
        addr_next = addr_reg;
        st_next = st_reg;
        ch_next = ch_reg;
        obuf_valid_next = obuf_valid_reg && out_stall;
        obuf_next = obuf_reg;
        cmd = '0;
        cmd.op = ba_pkg::DO_NONE;
        cmd.pool = pool_reg;
        cmd.lvl = j_reg;
        in_stall = (state_reg != S_IDLE) || !sts.clear_done;
        out_valid = obuf_valid_reg;
        out_data = obuf_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && sts.clear_done)
                begin
                    op_next = in_data.op;
                    pool_next = in_data.pool[0];
                    base_next = in_data.pool[0] ? base1 : base0;
                    addr_next = '0;
                    state_next = S_OUT;
                    if (in_data.op == ba_pkg::OP_ALLOC)
                    begin
                        lvl_next = alvl;
                        j_next = alvl;
                        if (in_data.req_size == 16'd0)
                            st_next = ba_pkg::ST_NULL;
                        else if (in_data.req_size > 16'(1 << ba_pkg::POOL_SIZE_LOG2)
                                 && ba_pkg::POOL_SIZE_LOG2 < 16)
                            st_next = ba_pkg::ST_NOMEM;
                        else if (in_data.pool[1])
                            st_next = ba_pkg::ST_BADPOOL;
                        else
                            state_next = S_SCAN;
                    end
                    else
                    begin
                        j_next = LW'(LV - 1);
                        if (in_data.block_addr == 32'd0)
                            st_next = ba_pkg::ST_NULL;
                        else if (in_data.pool[1])
                            st_next = ba_pkg::ST_BADPOOL;
                        else if (off >= 32'(1 << ba_pkg::POOL_SIZE_LOG2))
                            st_next = ba_pkg::ST_BADADDR;
                        else
                            state_next = S_CLIMB;
                    end
                end
            end
            S_SCAN:
            begin
                cmd.op = ba_pkg::DO_RD_HEAD;
                state_next = S_SCAN_W;
            end
            S_SCAN_W:
            begin
                if (sts.rdata != ba_pkg::NIL)
                begin
                    t_next = sts.rdata;
                    un_next = sts.rdata;
                    k_next = K_ALLOC;
                    state_next = S_UNL_N;
                end
                else if (j_reg == '0)
                begin
                    st_next = ba_pkg::ST_NOMEM;
                    state_next = S_OUT;
                end
                else
                begin
                    j_next = j_reg - 1'b1;
                    state_next = S_SCAN;
                end
            end
            // unlink un_reg from list j_reg
            S_UNL_N:
            begin
                cmd.op = ba_pkg::DO_RD_PREV;
                cmd.node = un_reg;
                state_next = S_UNL_P;
            end
            S_UNL_P:
            begin
                cmd.op = ba_pkg::DO_RD_NEXT;
                cmd.node = un_reg;
                pv_next = sts.rdata;
                state_next = S_UNL_A;
            end
            S_UNL_A:
            begin
                nx_next = sts.rdata;
                cmd.op = ba_pkg::DO_RD_HEAD;
                state_next = S_UNL_B;
            end
            S_UNL_B:
            begin
                if (pv_reg != ba_pkg::NIL)
                begin
                    cmd.op = ba_pkg::DO_WR_NEXT;
                    cmd.node = pv_reg;
                    cmd.data = nx_reg;
                end
                else if (sts.rdata == un_reg)
                begin
                    cmd.op = ba_pkg::DO_WR_HEAD;
                    cmd.data = nx_reg;
                end
                state_next = S_UNL_C;
            end
            S_UNL_C:
            begin
                if (nx_reg != ba_pkg::NIL)
                begin
                    cmd.op = ba_pkg::DO_WR_PREV;
                    cmd.node = nx_reg;
                    cmd.data = pv_reg;
                end
                state_next = S_UNL_D;
            end
            S_UNL_D:
            begin
                cmd.op = ba_pkg::DO_WR_NEXT;
                cmd.node = un_reg;
                cmd.data = ba_pkg::NIL;
                state_next = S_POST;
            end
            S_POST:
            begin
                cmd.op = ba_pkg::DO_WR_PREV;
                cmd.node = un_reg;
                cmd.data = ba_pkg::NIL;
                if (k_reg == K_ALLOC)
                    state_next = S_SPLIT;
                else
                begin
                    j_next = j_reg - 1'b1;
                    t_next = (t_reg - 1'b1) >> 1;
                    state_next = S_MERGE;
                end
            end
            S_SPLIT:
            begin
                cmd.op = ba_pkg::DO_WR_MARK;
                cmd.node = t_reg;
                cmd.data = NW'(1);
                if (j_reg < lvl_reg)
                begin
                    j_next = j_reg + 1'b1;
                    t_next = {t_reg[NW-2:0], 1'b1};
                    un_next = {t_reg[NW-2:0], 1'b0} + NW'(2);
                    k_next = K_SPLIT;
                    state_next = S_PUSH_H;
                end
                else
                    state_next = S_DONE;
            end
            // push un_reg onto list j_reg
            S_PUSH_H:
            begin
                cmd.op = ba_pkg::DO_RD_HEAD;
                state_next = S_PUSH_A;
            end
            S_PUSH_A:
            begin
                hd_next = sts.rdata;
                cmd.op = ba_pkg::DO_WR_NEXT;
                cmd.node = un_reg;
                cmd.data = sts.rdata;
                state_next = S_PUSH_B;
            end
            S_PUSH_B:
            begin
                cmd.op = ba_pkg::DO_WR_PREV;
                cmd.node = un_reg;
                cmd.data = ba_pkg::NIL;
                state_next = S_PUSH_C;
            end
            S_PUSH_C:
            begin
                if (hd_reg != ba_pkg::NIL)
                begin
                    cmd.op = ba_pkg::DO_WR_PREV;
                    cmd.node = hd_reg;
                    cmd.data = un_reg;
                end
                state_next = S_CH_W2;
            end
            S_CH_W2:
            begin
                cmd.op = ba_pkg::DO_WR_HEAD;
                cmd.data = un_reg;
                state_next = (k_reg == K_SPLIT) ? S_SPLIT : S_DONE;
            end
            S_CLIMB:
            begin
                cmd.op = ba_pkg::DO_RD_MARK;
                cmd.node = (j_reg == LW'(LV - 1)) ? leaf_t : t_reg;
                t_next = cmd.node;
                state_next = S_CLIMB_W;
            end
            S_CLIMB_W:
            begin
                if (sts.rdata[0])
                begin
                    if (j_reg == LW'(LV - 1))
                        state_next = S_MERGE;
                    else
                        state_next = S_CH1;
                end
                else if (j_reg == '0)
                begin
                    st_next = ba_pkg::ST_BADADDR;
                    state_next = S_OUT;
                end
                else
                begin
                    j_next = j_reg - 1'b1;
                    t_next = (t_reg - 1'b1) >> 1;
                    state_next = S_CLIMB;
                end
            end
            S_CH1:
            begin
                cmd.op = ba_pkg::DO_RD_MARK;
                cmd.node = {t_reg[NW-2:0], 1'b1};
                state_next = S_CH2;
            end
            S_CH2:
            begin
                cmd.op = ba_pkg::DO_RD_MARK;
                cmd.node = {t_reg[NW-2:0], 1'b0} + NW'(2);
                ch_next = sts.rdata[0];
                state_next = S_CH_W;
            end
            S_CH_W:
            begin
                if (ch_reg || sts.rdata[0])
                begin
                    st_next = ba_pkg::ST_BADADDR;
                    state_next = S_OUT;
                end
                else
                    state_next = S_MERGE;
            end
            S_MERGE:
            begin
                cmd.op = ba_pkg::DO_WR_MARK;
                cmd.node = t_reg;
                cmd.data = '0;
                un_next = t_reg;
                k_next = K_END;
                if (j_reg == '0)
                    state_next = S_PUSH_H;
                else
                    state_next = S_BUD;
            end
            S_BUD:
            begin
                cmd.op = ba_pkg::DO_RD_MARK;
                cmd.node = t_reg[0] ? t_reg + 1'b1 : t_reg - 1'b1;
                state_next = S_BUD_W;
            end
            S_BUD_W:
            begin
                if (sts.rdata[0])
                    state_next = S_PUSH_H;
                else
                begin
                    un_next = t_reg[0] ? t_reg + 1'b1 : t_reg - 1'b1;
                    k_next = K_MERGE;
                    state_next = S_UNL_N;
                end
            end
            S_DONE:
            begin
                st_next = ba_pkg::ST_OK;
                if (op_reg == ba_pkg::OP_ALLOC)
                    addr_next = base_reg + boff;
                state_next = S_OUT;
            end
            // hand the result to the output register
            S_OUT:
            begin
                if (!obuf_valid_reg || !out_stall)
                begin
                    obuf_valid_next = 1'b1;
                    obuf_next.addr_out = addr_reg;
                    obuf_next.status = st_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            obuf_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            obuf_valid_reg <= obuf_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        pool_reg <= pool_next;
        lvl_reg <= lvl_next;
        j_reg <= j_next;
        t_reg <= t_next;
        un_reg <= un_next;
        pv_reg <= pv_next;
        nx_reg <= nx_next;
        hd_reg <= hd_next;
        k_reg <= k_next;
        x_reg <= x_next;
        base_reg <= base_next;
        addr_reg <= addr_next;
        st_reg <= st_next;
        ch_reg <= ch_next;
        obuf_reg <= obuf_next;
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("request taken while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("result dropped under stall");
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status <= ba_pkg::ST_BADADDR))
        else $error("status out of range");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != ba_pkg::ST_OK) |-> (out_data.addr_out == 32'd0))
        else $error("failed request returned address");
`endif

endmodule

FILE: design/buddy_allocator.sv
// ----------------------------------------------------------------------------
// buddy_allocator
// binary buddy allocator for two pools with free lists per level
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid/in_stall   | in_data (req_t)
//  out     | out_valid/out_stall | out_data (rsp_t)
//  cfg     | cfg_we              | cfg_index, cfg_wdata
//
//  one request at a time; a search reads a list head and a climb reads a mark
//  at each tree level, and a split or merge uses the single-port memories in turn
//  longest request is a free merging from a leaf to the root
//  after reset a clearing pass sweeps the memories; no request is taken until
//  it ends
//  a result waits in an output register until out_stall is low, and the next
//  request can start meanwhile
// ----------------------------------------------------------------------------
module buddy_allocator (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  ba_pkg::req_t in_data,
    output logic         out_valid,
    input  logic         out_stall,
    output ba_pkg::rsp_t out_data,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    logic [31:0]  base0_reg, base1_reg;
    ba_pkg::cmd_t cmd;
    ba_pkg::sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base0_reg <= '0;
            base1_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ba_pkg::REG_POOL0: base0_reg <= cfg_wdata;
                ba_pkg::REG_POOL1: base1_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .base0(base0_reg), .base1(base1_reg),
        .cmd(cmd), .sts(sts));

    ba_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts));

endmodule

FILE: dv/ba_checker.sv
// ----------------------------------------------------------------------------
// ba_checker
// watches the request and result channels of the buddy allocator, predicts
// every result from its own model of both pools and compares field by field
// ----------------------------------------------------------------------------
module ba_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  ba_pkg::req_t  in_data,
    input  logic          out_valid,
    input  logic          out_stall,
    input  ba_pkg::rsp_t  out_data,
    input  logic          cfg_we,
    input  logic [0:0]    cfg_index,
    input  logic [31:0]   cfg_wdata,
    output int            fail_count,
    output int            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NOD = ba_pkg::NODES;
    localparam int LVS = ba_pkg::LEVELS;
    localparam int PSL = ba_pkg::POOL_SIZE_LOG2;
    localparam int MBL = ba_pkg::MIN_BLOCK_LOG2;
    localparam int NONE = -1;

    logic [31:0]  base_addr [2];
    bit           mark [2][NOD];
    int           head [2][LVS];
    int           nxt [2][NOD];
    int           prv [2][NOD];
    ba_pkg::rsp_t expected_rsp [$];

    assign pending = expected_rsp.size();

    function automatic void push_free(int p, int lvl, int n);
        int h;
        h = head[p][lvl];
        nxt[p][n] = h;
        prv[p][n] = NONE;
        if (h != NONE)
            prv[p][h] = n;
        head[p][lvl] = n;
    endfunction

    function automatic void unlink_free(int p, int lvl, int n);
        int pv;
        int nx;
        pv = prv[p][n];
        nx = nxt[p][n];
        if (pv != NONE)
            nxt[p][pv] = nx;
        else if (head[p][lvl] == n)
            head[p][lvl] = nx;
        if (nx != NONE)
            prv[p][nx] = pv;
        nxt[p][n] = NONE;
        prv[p][n] = NONE;
    endfunction

    function automatic ba_pkg::rsp_t take_block(int p, int size);
        ba_pkg::rsp_t r;
        int need;
        int pwr;
        int lvl;
        int j;
        int n;
        logic [31:0] off;
        r = '0;
        need = (size < (1 << MBL)) ? (1 << MBL) : size;
        pwr = 0;
        while (pwr < PSL && (1 << pwr) < need)
            pwr++;
        lvl = PSL - pwr;
        if (lvl >= LVS)
            lvl = LVS - 1;
        j = lvl;
        while (head[p][j] == NONE)
        begin
            if (j == 0)
            begin
                r.status = ba_pkg::ST_NOMEM;
                return r;
            end
            j--;
        end
        n = head[p][j];
        unlink_free(p, j, n);
        mark[p][n] = 1;
        while (j < lvl)
        begin
            j++;
            n = 2 * n + 1;
            push_free(p, j, n + 1);
            mark[p][n] = 1;
        end
        off = 32'((n - ((1 << j) - 1)) << (PSL - j));
        r.addr_out = base_addr[p] + off;
        r.status = ba_pkg::ST_OK;
        return r;
    endfunction

    function automatic logic [2:0] release_block(int p, logic [31:0] addr);
        logic [31:0] off;
        int x;
        int t;
        int k;
        int bud;
        off = addr - base_addr[p];
        if (off >= (32'd1 << PSL))
            return ba_pkg::ST_BADADDR;
        k = LVS - 1;
        x = int'(off >> MBL);
        t = x + (1 << k) - 1;
        while (!mark[p][t] && k > 0)
        begin
            k--;
            x >>= 1;
            t = x + (1 << k) - 1;
        end
        if (!mark[p][t])
            return ba_pkg::ST_BADADDR;
        if (k < LVS - 1 && (mark[p][2 * t + 1] || mark[p][2 * t + 2]))
            return ba_pkg::ST_BADADDR;
        forever
        begin
            mark[p][t] = 0;
            if (k == 0)
            begin
                push_free(p, 0, 0);
                break;
            end
            bud = (t & 1) ? t + 1 : t - 1;
            if (mark[p][bud])
            begin
                push_free(p, k, t);
                break;
            end
            unlink_free(p, k, bud);
            k--;
            t = (t - 1) >> 1;
        end
        return ba_pkg::ST_OK;
    endfunction

    function automatic ba_pkg::rsp_t predict_response(ba_pkg::req_t q);
        ba_pkg::rsp_t r;
        r = '0;
        if (q.op == ba_pkg::OP_ALLOC)
        begin
            if (q.req_size == 0)
                r.status = ba_pkg::ST_NULL;
            else if (q.req_size > (1 << PSL))
                r.status = ba_pkg::ST_NOMEM;
            else if (q.pool > 1)
                r.status = ba_pkg::ST_BADPOOL;
            else
                r = take_block(int'(q.pool), int'(q.req_size));
        end
        else
        begin
            if (q.block_addr == 0)
                r.status = ba_pkg::ST_NULL;
            else if (q.pool > 1)
                r.status = ba_pkg::ST_BADPOOL;
            else
                r.status = release_block(int'(q.pool), q.block_addr);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s got %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        base_addr[0] = '0;
        base_addr[1] = '0;
        for (int p = 0; p < 2; p++)
        begin
            for (int n = 0; n < NOD; n++)
            begin
                mark[p][n] = 0;
                nxt[p][n] = NONE;
                prv[p][n] = NONE;
            end
            for (int l = 0; l < LVS; l++)
                head[p][l] = NONE;
            head[p][0] = 0;
        end
    end

    always @(posedge clk)
    begin
        ba_pkg::rsp_t want;
        if (rst_n)
        begin
            if (cfg_we)
                base_addr[cfg_index] = cfg_wdata;
            if (in_valid && !in_stall)
                expected_rsp.push_back(predict_response(in_data));
            if (out_valid && !out_stall)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("unexpected result, status", 32'(out_data.status), '0);
                else
                begin
                    want = expected_rsp.pop_front();
                    if (out_data.addr_out !== want.addr_out)
                        report_mismatch("addr_out", out_data.addr_out, want.addr_out);
                    if (out_data.status !== want.status)
                        report_mismatch("status", 32'(out_data.status), 32'(want.status));
                end
            end
        end
    end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// drives allocate and free requests into the buddy allocator across several
// base settings and idle patterns; the checker predicts and compares
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    ba_pkg::req_t in_data;
    logic         out_valid;
    logic         out_stall;
    ba_pkg::rsp_t out_data;
    logic         cfg_we;
    logic [0:0]   cfg_index;
    logic [31:0]  cfg_wdata;
    int           fail_count;
    int           pending;

    int           send_idle;
    int           recv_stall;
    logic [31:0]  cur_base [2];

    buddy_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    ba_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall);

    // valid stays high into the next request when there is no idle gap
    task automatic send_request(logic op, logic [1:0] pool, logic [15:0] size,
                                logic [31:0] addr);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= '{op: op, pool: pool, req_size: size, block_addr: addr};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
    endtask

    task automatic set_base(logic [0:0] idx, logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        cur_base[idx] = value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // pick a size: mostly small, a few large
    function automatic logic [15:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 16'($urandom_range(1, 256));
        else if (r < 85)
            return 16'($urandom_range(1, 4096));
        else if (r < 95)
            return 16'($urandom_range(1, 32768));
        else
            return 16'($urandom());
    endfunction

    task automatic random_phase(int count);
        int r;
        logic [1:0] p;
        logic [31:0] a;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            p = ($urandom_range(19) == 0) ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1));
            if (r < 45)
                send_request(ba_pkg::OP_ALLOC, p, pick_size(), $urandom());
            else if (r < 85)
            begin
                // free an address near the base, aligned at a random level
                a = cur_base[p[0]] + (($urandom_range(32767)) &
                    ~((32'd1 << $urandom_range(5, 15)) - 1));
                if ($urandom_range(9) == 0)
                    a = a + $urandom_range(1, 31);
                send_request(ba_pkg::OP_FREE, p, 16'($urandom()), a);
            end
            else if (r < 93)
                send_request(ba_pkg::OP_FREE, p, 16'($urandom()), $urandom());
            else
                send_request(1'($urandom()), p, 16'($urandom_range(1)), 32'($urandom_range(1)));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        send_idle = 0;
        recv_stall = 0;
        cur_base[0] = '0;
        cur_base[1] = '0;
        repeat (2)
            @(negedge clk);
        rst_n = 1'b1;

        set_base(ba_pkg::REG_POOL0, 32'h0000_1000);
        set_base(ba_pkg::REG_POOL1, 32'hFFFF_C000);

        // directed
        send_request(ba_pkg::OP_ALLOC, 2'd0, 16'd0, '0);
        send_request(ba_pkg::OP_ALLOC, 2'd0, 16'hFFFF, '0);
        send_request(ba_pkg::OP_ALLOC, 2'd0, 16'd32769, '0);
        send_request(ba_pkg::OP_ALLOC, 2'd2, 16'd1, '0);
        send_request(ba_pkg::OP_ALLOC, 2'd3, 16'd100, '0);
        send_request(ba_pkg::OP_FREE, 2'd0, '0, 32'd0);
        send_request(ba_pkg::OP_FREE, 2'd3, '0, 32'h0000_1000);
        send_request(ba_pkg::OP_FREE, 2'd0, '0, 32'h0000_0FFF);
        send_request(ba_pkg::OP_FREE, 2'd0, '0, 32'h0000_9000);
        send_request(ba_pkg::OP_FREE, 2'd0, '0, 32'h0000_1000);
        send_request(ba_pkg::OP_ALLOC, 2'd0, 16'd1, '0);
        send_request(ba_pkg::OP_ALLOC, 2'd0, 16'd33, '0);
        send_request(ba_pkg::OP_FREE, 2'd0, '0, 32'h0000_1000);
        send_request(ba_pkg::OP_FREE, 2'd0, '0, 32'h0000_1045);
        send_request(ba_pkg::OP_FREE, 2'd0, '0, 32'h0000_1020);
        send_request(ba_pkg::OP_ALLOC, 2'd1, 16'd32768, '0);
        send_request(ba_pkg::OP_ALLOC, 2'd1, 16'd1, '0);
        send_request(ba_pkg::OP_FREE, 2'd1, '0, 32'hFFFF_FFFF);
        send_request(ba_pkg::OP_FREE, 2'd1, '0, 32'hFFFF_C000);
        send_request(ba_pkg::OP_ALLOC, 2'd1, 16'd32768, '0);
        send_request(ba_pkg::OP_FREE, 2'd1, '0, 32'hFFFF_C123);
        send_request(ba_pkg::OP_ALLOC, 2'd0, 16'hFFFF, 32'hFFFF_FFFF);
        send_request(ba_pkg::OP_FREE, 2'd1, 16'hFFFF, 32'h0000_0001);
        drain();

        set_base(ba_pkg::REG_POOL0, 32'hFFFF_FFFF);
        set_base(ba_pkg::REG_POOL1, 32'h0000_0000);
        random_phase(240);

        send_idle = 58;
        random_phase(230);
        drain();

        set_base(ba_pkg::REG_POOL0, 32'h8000_0000);
        set_base(ba_pkg::REG_POOL1, 32'h7FFF_8000);
        send_idle = 0;
        recv_stall = 58;
        random_phase(230);

        send_idle = 28;
        recv_stall = 28;
        random_phase(230);
        recv_stall = 0;
        drain();

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

endmodule
